FILE: rtl/vcds_pkg.sv
// Shared types, sizes and register codes for the variable-coefficient diffusion stencil.
// Depends on nothing; vcds_window, vcds_lane and the top level import it.
`timescale 1ns / 1ps
`default_nettype none
package vcds_pkg;

   // Largest interior grid the stores are sized for.
   localparam int MAX_X = 64;
   localparam int MAX_Y = 64;
   localparam int MAX_Z = 64;

   localparam int PLANE_MAX = (MAX_X + 2) * (MAX_Y + 2);
   localparam int WIN_DEPTH = 2 * PLANE_MAX + 1;
   localparam int WIN_AW    = $clog2(WIN_DEPTH);
   localparam int WIN_CW    = $clog2(WIN_DEPTH + 1);
   localparam int DLY_AW    = $clog2(PLANE_MAX);
   localparam int DLY_CW    = $clog2(PLANE_MAX + 1);

   // Field widths.
   localparam int CONC_W = 32;
   localparam int FRAC_W = 17;
   localparam int RATE_W = 16;
   localparam int SIZE_W = 7;
   localparam int CSR_W  = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

   // Mean-fraction arithmetic: s = fc + fn is Q1.17.
   localparam int S_W     = FRAC_W + 1;
   localparam logic [S_W-1:0] S_ONE = S_W'(131072);
   localparam int PROD_W  = RATE_W + S_W;
   localparam int R_SHIFT = 17;
   localparam int DIFF_W  = CONC_W + 1;
   localparam int TERM_W  = RATE_W + 1 + DIFF_W;
   localparam int SUM_W   = TERM_W + 3;
   localparam int NB_SHIFT = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_SOLID_RATE  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_LIQUID_RATE = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_X      = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Y      = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Z      = CSR_IDX_W'(4);

   // Window read ports: the centre and five stored face neighbours.
   localparam int N_RD      = 6;
   localparam int RD_CENTRE = 0;
   localparam int N_NBR     = 6;

   typedef struct packed {
      logic signed [CONC_W-1:0] conc;
      logic [FRAC_W-1:0]        frac;
      logic                     mold;
   } sample_type;

   // Load enables of the pipeline stages.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
      logic s6;
   } stage_ld_type;

endpackage
`default_nettype wire

FILE: rtl/vcds_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module vcds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read-first: a read and a write at one address return the old word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

FILE: rtl/vcds_window.sv
// Two-plane sample window: six RAM copies written together, each read at one stencil offset.
// Depends on vcds_pkg and vcds_ram.
`timescale 1ns / 1ps
`default_nettype none
module vcds_window (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   wr_en,
   input  wire logic                                   rd_en,
   input  wire logic [vcds_pkg::WIN_AW-1:0]            plane,
   input  wire logic [vcds_pkg::WIN_AW-1:0]            row,
   input  wire vcds_pkg::sample_type                   wr_sample,
   output vcds_pkg::sample_type [vcds_pkg::N_RD-1:0]   rd_sample
);
   import vcds_pkg::*;

   localparam int SW = $bits(sample_type);

   logic [WIN_AW-1:0] win_ptr_ff, win_ptr_in;
   logic [WIN_CW-1:0] fill_ff, fill_in;
   logic [N_RD-1:0]   vld_ff;
   logic [WIN_AW-1:0] back [N_RD];
   logic [WIN_AW-1:0] addr [N_RD];
   logic [SW-1:0]     q    [N_RD];

   function automatic logic [WIN_AW-1:0] wrap_sub(input logic [WIN_AW-1:0] ptr,
                                                   input logic [WIN_AW-1:0] b);
      logic [WIN_AW:0] t;
      t = {1'b0, ptr} + (WIN_AW+1)'(WIN_DEPTH) - {1'b0, b};
      if (ptr >= b) begin
         return ptr - b;
      end
      return t[WIN_AW-1:0];
   endfunction

   // Offsets back from the newest sample: centre, x-1, x+1, y-1, y+1, z-1.
   assign back[0] = plane;
   assign back[1] = plane + WIN_AW'(1);
   assign back[2] = plane - WIN_AW'(1);
   assign back[3] = plane + row;
   assign back[4] = plane - row;
   assign back[5] = {plane[WIN_AW-2:0], 1'b0};

   assign win_ptr_in = (win_ptr_ff == WIN_AW'(WIN_DEPTH - 1)) ? '0 : win_ptr_ff + WIN_AW'(1);
   assign fill_in    = (fill_ff == WIN_CW'(WIN_DEPTH)) ? fill_ff : fill_ff + WIN_CW'(1);

   for (genvar i = 0; i < N_RD; i++) begin : g_rd
      assign addr[i] = wrap_sub(win_ptr_ff, back[i]);

      vcds_ram #(.WIDTH(SW), .DEPTH(WIN_DEPTH)) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (win_ptr_ff),
         .wr_data (wr_sample),
         .rd_en   (rd_en),
         .rd_addr (addr[i]),
         .rd_data (q[i])
      );

      // Entries not yet written since reset read as zero.
      assign rd_sample[i] = vld_ff[i] ? sample_type'(q[i]) : '0;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (rd_en) begin
            vld_ff[i] <= WIN_CW'(addr[i]) < fill_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ptr_ff <= '0;
         fill_ff    <= '0;
      end else if (wr_en) begin
         win_ptr_ff <= win_ptr_in;
         fill_ff    <= fill_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/vcds_lane.sv
// One neighbour lane: mixed rate from the mean fraction, then rate times concentration step.
// Depends on vcds_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vcds_lane (
   input  wire logic                               clock,
   input  wire vcds_pkg::stage_ld_type             ld,
   input  wire logic [vcds_pkg::RATE_W-1:0]        solid_rate,
   input  wire logic [vcds_pkg::RATE_W-1:0]        liquid_rate,
   input  wire vcds_pkg::sample_type               centre,
   input  wire vcds_pkg::sample_type               nbr,
   output logic signed [vcds_pkg::TERM_W-1:0]      term
);
   import vcds_pkg::*;

   logic [S_W-1:0]           s_in;
   logic [PROD_W-1:0]        ps_ff, pl_ff;
   logic signed [DIFF_W-1:0] diff2_ff, diff3_ff;
   logic                     mold2_ff, mold3_ff;
   logic [PROD_W:0]          rsum;
   logic [RATE_W-1:0]        r16_ff;
   logic signed [RATE_W:0]   r_s;
   logic signed [TERM_W-1:0] prod;
   logic signed [TERM_W-1:0] term_in, term_ff;

   assign s_in = {1'b0, centre.frac} + {1'b0, nbr.frac};

   // Stage 2: the two rate products and the concentration difference.
   always_ff @(posedge clock) begin
      if (ld.s2) begin
         ps_ff    <= PROD_W'(solid_rate) * PROD_W'(s_in);
         pl_ff    <= PROD_W'(liquid_rate) * PROD_W'(S_ONE - s_in);
         diff2_ff <= {nbr.conc[CONC_W-1], nbr.conc} - {centre.conc[CONC_W-1], centre.conc};
         mold2_ff <= nbr.mold;
      end
   end

   // Stage 3: round the mixed rate to Q0.16.
   assign rsum = {1'b0, ps_ff} + {1'b0, pl_ff} + (PROD_W+1)'(1 << (R_SHIFT - 1));

   always_ff @(posedge clock) begin
      if (ld.s3) begin
         r16_ff   <= rsum[R_SHIFT +: RATE_W];
         diff3_ff <= diff2_ff;
         mold3_ff <= mold2_ff;
      end
   end

   // Stage 4: exact signed product; a mold neighbour contributes nothing.
   assign r_s     = $signed({1'b0, r16_ff});
   assign prod    = r_s * diff3_ff;
   assign term_in = mold3_ff ? '0 : prod;

   always_ff @(posedge clock) begin
      if (ld.s4) begin
         term_ff <= term_in;
      end
   end

   assign term = term_ff;
endmodule
`default_nettype wire

FILE: rtl/variable_coeff_diffusion_stencil.sv
// Top level of the variable-coefficient seven-point diffusion stencil.
// Depends on vcds_pkg, vcds_ram, vcds_window and vcds_lane.
`timescale 1ns / 1ps
`default_nettype none
// The block takes the cells of a 3D grid, padded by one cell on every side, in raster
// order (x fastest) on the req_ channel, one transaction per cell. Each interior cell
// yields one rsp_ transaction carrying its updated total concentration; padding cells
// yield none. rsp_last_cell marks the final interior cell of the grid.
// The csr_ port sets the two diffusion rates and the grid size; write it only while no
// transaction is in flight.
// There are six register stages, the first loaded at the accepting edge; rsp_valid is the
// valid bit of the sixth. The pipeline accepts one transaction per cycle while req_stall
// is low: the six window RAM copies (centre and five stored neighbours) are all read in
// the cycle a sample is written, and the sixth neighbour is the incoming sample itself.
// A result of cell (x, y, z) appears when the sample one plane later arrives, so the
// first result follows about two planes of input.
// Reset clears the position counters, the window and delay fill tracking and the
// pipeline valids; no clearing pass is needed and stored samples read as zero until
// written. When rsp_stall is high, the output register holds its result, the stages
// behind it fill their empty slots, and req_stall rises only once every stage is full.
module variable_coeff_diffusion_stencil (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [vcds_pkg::CONC_W-1:0]   req_liquid_conc,
   input  wire logic [vcds_pkg::FRAC_W-1:0]          req_solid_frac,
   input  wire logic                                 req_mold_flag,
   input  wire logic signed [vcds_pkg::CONC_W-1:0]   req_total_conc,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [vcds_pkg::CONC_W-1:0]        rsp_new_total_conc,
   output logic                                      rsp_last_cell,
   input  wire logic                                 csr_wr_en,
   input  wire logic [vcds_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [vcds_pkg::CSR_W-1:0]           csr_wr_data
);
   import vcds_pkg::*;

   localparam int RS_W  = SUM_W + 1;
   localparam int NB_W  = RS_W - NB_SHIFT;
   localparam int RES_W = NB_W + 1;

   // Configuration registers.
   logic [RATE_W-1:0] solid_rate_ff, liquid_rate_ff;
   logic [SIZE_W-1:0] size_x_ff, size_y_ff, size_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         solid_rate_ff  <= '0;
         liquid_rate_ff <= '0;
         size_x_ff      <= SIZE_W'(64);
         size_y_ff      <= SIZE_W'(64);
         size_z_ff      <= SIZE_W'(64);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_SOLID_RATE:  solid_rate_ff  <= csr_wr_data[RATE_W-1:0];
            REG_LIQUID_RATE: liquid_rate_ff <= csr_wr_data[RATE_W-1:0];
            REG_SIZE_X:      size_x_ff      <= csr_wr_data[SIZE_W-1:0];
            REG_SIZE_Y:      size_y_ff      <= csr_wr_data[SIZE_W-1:0];
            REG_SIZE_Z:      size_z_ff      <= csr_wr_data[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // A size of zero counts as one; a size above the store limit counts as the limit.
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v, input int maxv);
      if (v == '0) begin
         return SIZE_W'(1);
      end
      if (int'(v) > maxv) begin
         return SIZE_W'(maxv);
      end
      return v;
   endfunction

   logic [SIZE_W-1:0] ex, ey, ez;
   logic [WIN_AW-1:0] row, plane;

   assign ex    = eff_size(size_x_ff, MAX_X);
   assign ey    = eff_size(size_y_ff, MAX_Y);
   assign ez    = eff_size(size_z_ff, MAX_Z);
   assign row   = WIN_AW'(ex) + WIN_AW'(2);
   assign plane = row * (WIN_AW'(ey) + WIN_AW'(2));

   // Pipeline load enables: a stage loads when it is empty or the stage after it loads.
   stage_ld_type ld;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic accept;

   assign ld.s6 = !v6_ff || !rsp_stall;
   assign ld.s5 = !v5_ff || ld.s6;
   assign ld.s4 = !v4_ff || ld.s5;
   assign ld.s3 = !v3_ff || ld.s4;
   assign ld.s2 = !v2_ff || ld.s3;
   assign ld.s1 = !v1_ff || ld.s2;

   assign req_stall = !ld.s1;
   assign accept    = req_valid && ld.s1;

   // Padded position of the incoming cell; its centre lies one plane behind.
   logic [SIZE_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic interior, last_in;

   assign interior = (pos_x_ff >= SIZE_W'(1)) && (pos_x_ff <= ex) &&
                     (pos_y_ff >= SIZE_W'(1)) && (pos_y_ff <= ey) &&
                     (pos_z_ff >= SIZE_W'(2)) && (pos_z_ff <= ez + SIZE_W'(1));
   assign last_in  = (pos_x_ff == ex) && (pos_y_ff == ey) && (pos_z_ff == ez + SIZE_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
      end else if (accept) begin
         if (pos_x_ff >= ex + SIZE_W'(1)) begin
            pos_x_ff <= '0;
            if (pos_y_ff >= ey + SIZE_W'(1)) begin
               pos_y_ff <= '0;
               pos_z_ff <= (pos_z_ff >= ez + SIZE_W'(1)) ? '0 : pos_z_ff + SIZE_W'(1);
            end else begin
               pos_y_ff <= pos_y_ff + SIZE_W'(1);
            end
         end else begin
            pos_x_ff <= pos_x_ff + SIZE_W'(1);
         end
      end
   end

   // Incoming sample with the solid fraction clamped to one.
   sample_type in_sample;

   assign in_sample.conc = req_liquid_conc;
   assign in_sample.frac = (req_solid_frac > FRAC_ONE) ? FRAC_ONE : req_solid_frac;
   assign in_sample.mold = req_mold_flag;

   sample_type [N_RD-1:0] rd_sample;

   vcds_window u_window (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (accept),
      .rd_en     (ld.s1),
      .plane     (plane),
      .row       (row),
      .wr_sample (in_sample),
      .rd_sample (rd_sample)
   );

   // Total concentration delay line, one plane long; prefix fill mark for reset zeros.
   logic [DLY_CW-1:0] dly_ptr_ff, dly_hwm_ff, dp, dp_inc;
   logic [CONC_W-1:0] dly_q;
   logic              old_vld_ff;

   assign dp     = (WIN_AW'(dly_ptr_ff) >= plane) ? '0 : dly_ptr_ff;
   assign dp_inc = dp + DLY_CW'(1);

   vcds_ram #(.WIDTH(CONC_W), .DEPTH(PLANE_MAX)) u_delay (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (dp[DLY_AW-1:0]),
      .wr_data (req_total_conc),
      .rd_en   (ld.s1),
      .rd_addr (dp[DLY_AW-1:0]),
      .rd_data (dly_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         dly_ptr_ff <= '0;
         dly_hwm_ff <= '0;
         old_vld_ff <= 1'b0;
      end else begin
         if (accept) begin
            dly_ptr_ff <= (WIN_AW'(dp_inc) >= plane) ? '0 : dp_inc;
            if (dp_inc > dly_hwm_ff) begin
               dly_hwm_ff <= dp_inc;
            end
         end
         if (ld.s1) begin
            old_vld_ff <= dp < dly_hwm_ff;
         end
      end
   end

   // Stage 1 side registers: the newest sample is the upper z neighbour.
   sample_type               inc1_ff;
   logic                     last1_ff, last2_ff, last3_ff, last4_ff, last5_ff;
   logic signed [CONC_W-1:0] old1, old2_ff, old3_ff, old4_ff, old5_ff;

   assign old1 = old_vld_ff ? $signed(dly_q) : '0;

   always_ff @(posedge clock) begin
      if (ld.s1) begin
         inc1_ff  <= in_sample;
         last1_ff <= last_in;
      end
      if (ld.s2) begin
         old2_ff  <= old1;
         last2_ff <= last1_ff;
      end
      if (ld.s3) begin
         old3_ff  <= old2_ff;
         last3_ff <= last2_ff;
      end
      if (ld.s4) begin
         old4_ff  <= old3_ff;
         last4_ff <= last3_ff;
      end
      if (ld.s5) begin
         old5_ff  <= old4_ff;
         last5_ff <= last4_ff;
      end
   end

   // Six neighbour lanes: five from the window, one from the newest sample.
   sample_type               nbr [N_NBR];
   logic signed [TERM_W-1:0] term [N_NBR];

   for (genvar i = 0; i < N_NBR; i++) begin : g_lane
      if (i == RD_CENTRE) begin : g_inc
         assign nbr[i] = inc1_ff;
      end else begin : g_win
         assign nbr[i] = rd_sample[i];
      end

      vcds_lane u_lane (
         .clock       (clock),
         .ld          (ld),
         .solid_rate  (solid_rate_ff),
         .liquid_rate (liquid_rate_ff),
         .centre      (rd_sample[RD_CENTRE]),
         .nbr         (nbr[i]),
         .term        (term[i])
      );
   end

   // Stage 5: exact sum of the six terms.
   logic signed [SUM_W-1:0] sum_in, sum_ff;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < N_NBR; i++) begin
         sum_in = sum_in + SUM_W'(term[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ld.s5) begin
         sum_ff <= sum_in;
      end
   end

   // Stage 6: round to Q8.24 (ties up), add to the old total, saturate.
   logic signed [RS_W-1:0]   rs;
   logic signed [NB_W-1:0]   nb;
   logic signed [RES_W-1:0]  res;
   logic signed [CONC_W-1:0] sat;
   logic [RES_W-CONC_W:0]    top_bits;

   assign rs       = RS_W'(sum_ff) + RS_W'(1 << (NB_SHIFT - 1));
   assign nb       = rs[RS_W-1:NB_SHIFT];
   assign res      = RES_W'(nb) + RES_W'(old5_ff);
   assign top_bits = res[RES_W-1:CONC_W-1];

   always_comb begin
      if ((&top_bits) || !(|top_bits)) begin
         sat = res[CONC_W-1:0];
      end else if (res[RES_W-1]) begin
         sat = {1'b1, {(CONC_W-1){1'b0}}};
      end else begin
         sat = {1'b0, {(CONC_W-1){1'b1}}};
      end
   end

   logic signed [CONC_W-1:0] out_ff;
   logic                     last6_ff;

   always_ff @(posedge clock) begin
      if (ld.s6) begin
         out_ff   <= sat;
         last6_ff <= last5_ff;
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (ld.s1) v1_ff <= accept && interior;
         if (ld.s2) v2_ff <= v1_ff;
         if (ld.s3) v3_ff <= v2_ff;
         if (ld.s4) v4_ff <= v3_ff;
         if (ld.s5) v5_ff <= v4_ff;
         if (ld.s6) v6_ff <= v5_ff;
      end
   end

   assign rsp_valid          = v6_ff;
   assign rsp_new_total_conc = out_ff;
   assign rsp_last_cell      = last6_ff;
endmodule
`default_nettype wire
